// File: src/page_framebuffer_xor_draw_core_defines.svh
// assertion macros shared by the page frame store drawing block
// expects signals named clk and arst_n in the module that uses them
`ifndef PAGE_FRAMEBUFFER_XOR_DRAW_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_XOR_DRAW_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define PFXD_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfxd assertion failed");

// next-cycle implication, held off during reset
`define PFXD_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfxd assertion failed");

`endif

// File: src/pfxd_pkg.sv
// shared types, request codes and helpers for the page frame store drawing block
// no dependencies; used by every module of the block
package pfxd_pkg;

	// default panel geometry
	localparam int unsigned DEF_DISP_WIDTH  = 128;
	localparam int unsigned DEF_DISP_HEIGHT = 64;

	// internal byte address width, wide enough for any column/page reach
	localparam int unsigned FULL_AW = 14;

	// request codes
	localparam logic [2:0] REQ_PLOT  = 3'd0;
	localparam logic [2:0] REQ_HLINE = 3'd1;
	localparam logic [2:0] REQ_VLINE = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic [7:0] PAT_REFILL = 8'h80;
	localparam logic [7:0] BYTE_ONES  = 8'hff;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [7:0]        x;
		logic [7:0]        y;
		logic signed [7:0] length;
		logic [7:0]        pattern;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       out_of_range;
	} rsp_t;

	// frame store access, one read and one write port
	typedef struct packed {
		logic               rd_en;
		logic [FULL_AW-1:0] rd_addr;
		logic               wr_en;
		logic [FULL_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
	} mem_req_t;

	// bits lo..hi set
	function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
		span_mask = (BYTE_ONES << lo) & (BYTE_ONES >> (3'd7 - hi));
	endfunction

endpackage

// File: src/pfxd_store.sv
// frame store memory: one write and one read port, registered read data
// depends on pfxd_pkg for the access struct
module pfxd_store #(
	parameter int unsigned DEPTH = (pfxd_pkg::DEF_DISP_WIDTH * pfxd_pkg::DEF_DISP_HEIGHT) / 8
) (
	input  logic              clk,
	input  pfxd_pkg::mem_req_t mem_req,
	output logic [7:0]        rdata
);
	import pfxd_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
		end
	end

	// read port, forwards a same-cycle write, holds when idle
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			if (mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr)) begin
				rd_q <= mem_req.wr_data;
			end else begin
				rd_q <= mem[mem_req.rd_addr[AW-1:0]];
			end
		end
	end

	assign rdata = rd_q;

endmodule

// File: src/pfxd_seq.sv
// request sequencer: address stepping, read-modify-write and clear sweep
// depends on pfxd_pkg and the assertion macro header
`include "page_framebuffer_xor_draw_core_defines.svh"

module pfxd_seq #(
	parameter int unsigned DISP_WIDTH  = pfxd_pkg::DEF_DISP_WIDTH,
	parameter int unsigned DISP_HEIGHT = pfxd_pkg::DEF_DISP_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pfxd_pkg::req_t     req_data,
	input  logic               out_free,
	output logic               rsp_load,
	output pfxd_pkg::rsp_t     rsp_next,
	output pfxd_pkg::mem_req_t mem_req,
	input  logic [7:0]         rdata
);
	import pfxd_pkg::*;

	localparam int unsigned STORE_BYTES = (DISP_WIDTH * DISP_HEIGHT) / 8;
	localparam logic [FULL_AW-1:0] STORE_END  = FULL_AW'(STORE_BYTES);
	localparam logic [FULL_AW-1:0] LAST_ADDR  = FULL_AW'(STORE_BYTES - 1);
	localparam logic [FULL_AW-1:0] WIDTH_STEP = FULL_AW'(DISP_WIDTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	logic [1:0]         state_q;
	logic               init_q;
	logic [2:0]         op_q;
	logic [FULL_AW-1:0] addr_q;
	logic [7:0]         cnt_q;
	logic [7:0]         pat_q;
	logic [2:0]         bit_q;
	logic [2:0]         hi_q;
	logic               first_q;
	logic               oor_q;
	logic               rd_hit_q;

	logic               wb_valid_s1;
	logic [FULL_AW-1:0] wb_addr_s1;
	logic [7:0]         wb_mask_s1;

	logic               req_accept;
	logic               neg;
	logic [7:0]         mag;
	logic [7:0]         x_eff;
	logic [FULL_AW-1:0] base;
	logic [8:0]         last_row;
	logic [5:0]         vpages;
	logic [7:0]         cnt_init;

	logic               step_act;
	logic               step_wr;
	logic               step_rd;
	logic [7:0]         step_mask;
	logic               in_range;
	logic               issue;

	// request decode at accept
	always_comb begin
		neg      = req_data.length[7];
		mag      = neg ? 8'(~req_data.length + 8'sd1) : req_data.length;
		x_eff    = (req_data.req_type == REQ_HLINE && neg) ?
			8'(req_data.x + req_data.length) : req_data.x;
		base     = FULL_AW'(req_data.y[7:3]) * WIDTH_STEP + FULL_AW'(x_eff);
		last_row = {1'b0, req_data.y} + {1'b0, mag} - 9'd1;
		vpages   = last_row[8:3] - {1'b0, req_data.y[7:3]} + 6'd1;
		unique case (req_data.req_type) inside
			REQ_PLOT, REQ_READ: cnt_init = 8'd1;
			REQ_HLINE:          cnt_init = mag;
			REQ_VLINE:          cnt_init = (!neg && mag != 8'd0) ? {2'b00, vpages} : 8'd0;
			default:            cnt_init = 8'd0;
		endcase
	end

	// one step of the current request
	always_comb begin
		step_act  = (state_q == ST_RUN) && (cnt_q != 8'd0);
		step_wr   = 1'b0;
		step_rd   = 1'b0;
		step_mask = 8'd1 << bit_q;
		case (op_q)
			REQ_PLOT:  step_wr = 1'b1;
			REQ_HLINE: step_wr = pat_q[0];
			REQ_VLINE: begin
				step_wr   = 1'b1;
				step_mask = span_mask(first_q ? bit_q : 3'd0,
					(cnt_q == 8'd1) ? hi_q : 3'd7);
			end
			REQ_READ:  step_rd = 1'b1;
			default:   step_wr = 1'b0;
		endcase
		in_range = addr_q < STORE_END;
		issue    = step_act && (step_wr || step_rd) && in_range;
	end

	// handshake and result
	assign rsp_load   = (state_q == ST_FIN) && out_free;
	assign req_stall  = !((state_q == ST_IDLE) || rsp_load);
	assign req_accept = req_valid && !req_stall;

	assign rsp_next.read_data    = rd_hit_q ? rdata : 8'd0;
	assign rsp_next.out_of_range = oor_q;

	// memory ports: step read, write-back of the previous step, clear sweep
	always_comb begin
		mem_req.rd_en   = issue;
		mem_req.rd_addr = addr_q;
		mem_req.wr_en   = wb_valid_s1 || (state_q == ST_CLEAR);
		mem_req.wr_addr = (state_q == ST_CLEAR) ? addr_q : wb_addr_s1;
		mem_req.wr_data = (state_q == ST_CLEAR) ? 8'd0 : (rdata ^ wb_mask_s1);
	end

	// write-back stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_s1 <= 1'b0;
		end else begin
			wb_valid_s1 <= issue && step_wr;
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= addr_q;
		wb_mask_s1 <= step_mask;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			init_q   <= 1'b1;
			addr_q   <= '0;
			cnt_q    <= '0;
			op_q     <= REQ_PLOT;
			oor_q    <= 1'b0;
			rd_hit_q <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			if (req_accept) begin
				op_q     <= req_data.req_type;
				cnt_q    <= cnt_init;
				first_q  <= 1'b1;
				oor_q    <= 1'b0;
				rd_hit_q <= 1'b0;
				if (req_data.req_type == REQ_CLEAR) begin
					addr_q  <= '0;
					state_q <= ST_CLEAR;
				end else begin
					addr_q  <= base;
					state_q <= ST_RUN;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: state_q <= ST_IDLE;
					ST_RUN: begin
						if (step_act) begin
							cnt_q   <= cnt_q - 8'd1;
							first_q <= 1'b0;
							addr_q  <= addr_q + ((op_q == REQ_VLINE) ? WIDTH_STEP :
								FULL_AW'(1));
							if ((step_wr || step_rd) && !in_range) begin
								oor_q <= 1'b1;
							end
							if (issue && step_rd) begin
								rd_hit_q <= 1'b1;
							end
						end
						if (cnt_q <= 8'd1) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						if (rsp_load) begin
							state_q <= ST_IDLE;
						end
					end
					ST_CLEAR: begin
						addr_q <= addr_q + FULL_AW'(1);
						if (addr_q == LAST_ADDR) begin
							init_q  <= 1'b0;
							state_q <= init_q ? ST_IDLE : ST_FIN;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// horizontal stipple walk; start bit and last-row bit latched at accept
	always_ff @(posedge clk) begin
		if (req_accept) begin
			pat_q <= req_data.pattern;
			bit_q <= req_data.y[2:0];
			hi_q  <= last_row[2:0];
		end else if (step_act) begin
			pat_q <= pat_q[0] ? ((pat_q >> 1) | PAT_REFILL) : (pat_q >> 1);
		end
	end

	// a write-back always pairs with the read in the previous cycle
	`PFXD_AST_IMP(a_wb_follows_read, wb_valid_s1, $past(mem_req.rd_en))
	// nothing is taken while the power-up sweep runs
	`PFXD_AST_IMP(a_no_req_in_init, init_q, req_stall)
	// the memory is never read past its end
	`PFXD_AST_IMP(a_read_in_range, mem_req.rd_en, mem_req.rd_addr < STORE_END)

endmodule

// File: src/page_framebuffer_xor_draw_core.sv
// top level of the monochrome page frame store with XOR drawing
// depends on pfxd_pkg, pfxd_store and pfxd_seq
//
// Usage:
//  - request channel req_valid/req_stall/req_data carries one command: plot,
//    stippled horizontal line, vertical line, clear or byte read.
//  - response channel rsp_valid/rsp_stall/rsp_data returns exactly one
//    response per request: the read byte (zero for non-reads) and a flag set
//    when any addressed byte lay past the end of the store.
//  - for each drawn byte the sequencer issues the memory read, and the XORed
//    byte is written back the next cycle while the following byte is read.
//    A closing state then hands the response over.
//  - bytes stepped over: plot and read a single byte, horizontal line
//    |length| bytes, vertical line the pages spanned, none when the length
//    is zero (or, for a vertical line, negative), as for unused codes.
//    clear: memory sweep.
//  - after reset the store is swept to zero with req_stall high.
//  - a response waiting under rsp_stall sits in the output register; the
//    next request is accepted and worked on, and only its hand-over waits.
module page_framebuffer_xor_draw_core #(
	parameter int unsigned DISP_WIDTH  = pfxd_pkg::DEF_DISP_WIDTH,
	parameter int unsigned DISP_HEIGHT = pfxd_pkg::DEF_DISP_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pfxd_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfxd_pkg::rsp_t rsp_data
);
	import pfxd_pkg::*;

	localparam int unsigned STORE_BYTES = (DISP_WIDTH * DISP_HEIGHT) / 8;

	mem_req_t   mem_req;
	logic [7:0] rdata;
	logic       out_free;
	logic       rsp_load;
	rsp_t       rsp_next;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	pfxd_store #(
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	pfxd_seq #(
		.DISP_WIDTH  (DISP_WIDTH),
		.DISP_HEIGHT (DISP_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.out_free  (out_free),
		.rsp_load  (rsp_load),
		.rsp_next  (rsp_next),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	// response register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= rsp_load;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: tb/sv/page_framebuffer_xor_draw_core_test.sv
// self-checking testbench for the monochrome page frame store with XOR drawing
// depends on pfxd_pkg and page_framebuffer_xor_draw_core; directed table, then random requests
`timescale 1ns / 100ps

module page_framebuffer_xor_draw_core_test;
	import pfxd_pkg::*;

	localparam int unsigned STORE_BYTES = DEF_DISP_WIDTH * DEF_DISP_HEIGHT / 8;
	localparam int unsigned RANDOM_REQS = 850;

	// request codes the block ignores
	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	// shadow copy of the frame store and responses still owed by the block
	logic [7:0] shadow_store [STORE_BYTES];
	rsp_t       rsp_expected [$];
	int         mismatch_count = 0;
	int         req_count = 0;
	bit         calm = 1'b0;
	bit         hold_rsp = 1'b0;

	page_framebuffer_xor_draw_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always #6 clk = ~clk;

	// byte address of a page and column, no clipping to the page row
	function automatic int unsigned byte_at(input int unsigned page, input logic [7:0] col);
		return page * DEF_DISP_WIDTH + int'(col);
	endfunction

	// xor into the shadow store, returns 1 when the byte lies past the end
	function automatic logic xor_into(input int unsigned idx, input logic [7:0] mask);
		if (idx >= STORE_BYTES)
			return 1'b1;
		shadow_store[idx] ^= mask;
		return 1'b0;
	endfunction

	// apply one request to the shadow store and work out its response
	function automatic rsp_t draw_predict(input req_t rq);
		rsp_t        o;
		logic [7:0]  lraw;
		logic [7:0]  col;
		logic [7:0]  stip;
		logic [7:0]  bit_mask;
		logic        neg;
		int unsigned cnt;
		int unsigned base;
		int unsigned first;
		int unsigned last;
		int unsigned lo;
		int unsigned hi;
		o        = '0;
		lraw     = rq.length;
		neg      = lraw[7];
		cnt      = neg ? 256 - int'(lraw) : int'(lraw);
		col      = rq.x;
		stip     = rq.pattern;
		bit_mask = 8'd1 << rq.y[2:0];
		case (rq.req_type)
			REQ_PLOT: begin
				o.out_of_range = xor_into(byte_at(32'(rq.y >> 3), rq.x), bit_mask);
			end
			REQ_HLINE: begin
				// negative width moves the start left, wrapping in 8 bits
				if (neg)
					col = rq.x + lraw;
				base = byte_at(32'(rq.y >> 3), col);
				for (int unsigned i = 0; i < cnt; i++) begin
					if (stip[0]) begin
						o.out_of_range |= xor_into(base + i, bit_mask);
						stip = (stip >> 1) | PAT_REFILL;
					end else begin
						stip = stip >> 1;
					end
				end
			end
			REQ_VLINE: begin
				if (!neg && cnt != 0) begin
					first = 32'(rq.y);
					last  = first + cnt - 1;
					for (int unsigned pg = first >> 3; pg <= (last >> 3); pg++) begin
						lo = (pg == (first >> 3)) ? (first & 7) : 0;
						hi = (pg == (last >> 3)) ? (last & 7) : 7;
						o.out_of_range |= xor_into(byte_at(pg, rq.x),
							8'((32'hff << lo) & (32'hff >> (7 - hi))));
					end
				end
			end
			REQ_CLEAR: begin
				foreach (shadow_store[i])
					shadow_store[i] = 8'h00;
			end
			REQ_READ: begin
				base = byte_at(32'(rq.y >> 3), rq.x);
				if (base < STORE_BYTES)
					o.read_data = shadow_store[base];
				else
					o.out_of_range = 1'b1;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic stim_row_t dir_row(input logic [2:0] op, input logic [7:0] x,
		input logic [7:0] y, input logic [7:0] len, input logic [7:0] pat,
		input bit typed, input logic [7:0] rd, input logic oor);
		stim_row_t r;
		r.rq.req_type      = op;
		r.rq.x             = x;
		r.rq.y             = y;
		r.rq.length        = len;
		r.rq.pattern       = pat;
		r.typed            = typed;
		r.want.read_data   = rd;
		r.want.out_of_range = oor;
		return r;
	endfunction

	// random request, mostly inside the panel and with short lines
	function automatic req_t random_request();
		req_t rq;
		int   k;
		k = $urandom_range(99);
		if (k < 25)
			rq.req_type = REQ_PLOT;
		else if (k < 45)
			rq.req_type = REQ_HLINE;
		else if (k < 65)
			rq.req_type = REQ_VLINE;
		else if (k < 93)
			rq.req_type = REQ_READ;
		else if (k < 95)
			rq.req_type = REQ_CLEAR;
		else
			rq.req_type = 3'($urandom_range(7, 5));
		rq.x       = ($urandom_range(99) < 80) ? 8'($urandom_range(127)) : 8'($urandom);
		rq.y       = ($urandom_range(99) < 85) ? 8'($urandom_range(63)) : 8'($urandom);
		rq.pattern = 8'($urandom);
		if (rq.req_type == REQ_VLINE)
			rq.length = ($urandom_range(99) < 80) ? 8'($urandom_range(64)) : 8'($urandom);
		else
			rq.length = ($urandom_range(99) < 85) ? 8'(int'($urandom_range(32)) - 16)
				: 8'($urandom);
		return rq;
	endfunction

	// offer one request until accepted, then record what it should return
	task automatic issue(input req_t rq, input bit typed, input rsp_t typed_rsp);
		rsp_t model_rsp;
		if (!calm && $urandom_range(99) < 18) begin
			req_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		req_valid = 1'b1;
		req_data  = rq;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		model_rsp = draw_predict(rq);
		rsp_expected.push_back(typed ? typed_rsp : model_rsp);
		req_count++;
		@(negedge clk);
	endtask

	// pause the sender until every owed response has come back
	task automatic drain();
		req_valid = 1'b0;
		while (rsp_expected.size() != 0)
			@(negedge clk);
	endtask

	// response side stall, random or held off
	always @(negedge clk) begin
		rsp_stall = hold_rsp || (!calm && $urandom_range(99) < 18);
	end

	// long receiver hold-off so the block backs up into its request side
	initial begin
		while (req_count < 200)
			@(negedge clk);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
	end

	// compare each accepted response with the oldest owed one
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected response read_data=%02h out_of_range=%0b",
						rsp_data.read_data, rsp_data.out_of_range);
				mismatch_count++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp_data.read_data !== want.read_data ||
					rsp_data.out_of_range !== want.out_of_range) begin
					if (mismatch_count < 10)
						$display("mismatch: read_data exp %02h got %02h, out_of_range exp %0b got %0b",
							want.read_data, rsp_data.read_data,
							want.out_of_range, rsp_data.out_of_range);
					mismatch_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		stim_row_t dir_rows [$];
		foreach (shadow_store[i])
			shadow_store[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: corners, every request code, wrap and past-end cases
		dir_rows.push_back(dir_row(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd127, 8'd63, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd0, 8'd64, 8'h00, 8'h00, 1, 8'h00, 1'b1));
		dir_rows.push_back(dir_row(REQ_READ, 8'd255, 8'd255, 8'hff, 8'hff, 1, 8'h00, 1'b1));
		dir_rows.push_back(dir_row(REQ_PLOT, 8'd0, 8'd0, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00, 1, 8'h01, 1'b0));
		dir_rows.push_back(dir_row(REQ_PLOT, 8'd255, 8'd255, 8'h7f, 8'hff, 1, 8'h00, 1'b1));
		dir_rows.push_back(dir_row(REQ_PLOT, 8'd127, 8'd63, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd127, 8'd63, 8'h00, 8'h00, 1, 8'h80, 1'b0));
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd0, 8'd8, 8'd127, 8'hff, 0, 8'h00, 1'b0));
		// most negative width, start wraps and runs into the next page
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd10, 8'd16, 8'h80, 8'h55, 0, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd2, 8'd3, 8'hfb, 8'h01, 0, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd40, 8'd20, 8'h00, 8'hff, 1, 8'h00, 1'b0));
		// all-zero stipple past the end writes nothing, so no flag
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd200, 8'd63, 8'd100, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_HLINE, 8'd120, 8'd56, 8'd127, 8'hff, 1, 8'h00, 1'b1));
		dir_rows.push_back(dir_row(REQ_VLINE, 8'd5, 8'd0, 8'd64, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_VLINE, 8'd5, 8'd3, 8'hff, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_VLINE, 8'd6, 8'd3, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		// vertical run starting on the last rows goes past row 255
		dir_rows.push_back(dir_row(REQ_VLINE, 8'd9, 8'd250, 8'd60, 8'h00, 1, 8'h00, 1'b1));
		dir_rows.push_back(dir_row(REQ_VLINE, 8'd7, 8'd60, 8'd20, 8'h00, 0, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd5, 8'd0, 8'h00, 8'h00, 0, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_SPARE_5, 8'd0, 8'd0, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_SPARE_6, 8'd255, 8'd255, 8'hff, 8'hff, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_SPARE_7, 8'd1, 8'd1, 8'h01, 8'h01, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_CLEAR, 8'd0, 8'd0, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(dir_row(REQ_READ, 8'd0, 8'd8, 8'h00, 8'h00, 1, 8'h00, 1'b0));
		foreach (dir_rows[i])
			issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// random part, with a drain midway and a stretch with no idling
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == 500)
				drain();
			calm = (n >= 600 && n < 750);
			issue(random_request(), 0, '0);
		end
		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
